// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Users supply clk and rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clk edge outside reset.
`define CHK_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Plain invariant checked on every rising clk edge outside reset.
`define CHK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/psps_pkg.sv =====
// Shared types and constants for the printable string pool scanner.
// No dependencies; used by every module of the block.
`default_nettype none

package psps_pkg;

    localparam int LEN_W = 13;
    localparam int CNT_W = 5;

    localparam logic [LEN_W-1:0] RUN_CAP   = 13'd4096;
    localparam logic [CNT_W-1:0] MAX_POOLS = 5'd16;
    localparam logic [1:0]       SKIP_BYTES = 2'd3;

    localparam logic [31:0]      BASE_RST  = 32'h0800_0000;
    localparam logic [LEN_W-1:0] MIN_RST   = 13'd24;
    localparam logic [LEN_W-1:0] MAX_RST   = 13'd4096;
    localparam logic [CNT_W-1:0] LIMIT_RST = 5'd16;

    localparam int FQ_DEPTH = 4;
    localparam int FQ_AW    = 2;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;

    typedef enum logic [1:0] {
        REG_BASE  = 2'd0,
        REG_MIN   = 2'd1,
        REG_MAX   = 2'd2,
        REG_LIMIT = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        CLS_PRINT = 2'd0,
        CLS_ZERO  = 2'd1,
        CLS_OTHER = 2'd2
    } byte_class_t;

    typedef enum logic {
        MODE_IDLE = 1'b0,
        MODE_RUN  = 1'b1
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } psps_in_t;

    typedef struct packed {
        logic             pool_valid;
        logic [31:0]      pool_start;
        logic [LEN_W-1:0] pool_length;
        logic             scan_done;
        logic [CNT_W-1:0] pools_total;
    } psps_out_t;

    typedef struct packed {
        byte_class_t cls;
        logic        last;
    } cls_item_t;

    typedef struct packed {
        logic [1:0] cnt;
        psps_out_t  rec1;
        psps_out_t  rec0;
    } rec_wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/psps_front.sv =====
// Front end: classifies incoming bytes and buffers them in a short queue.
// Depends on psps_pkg.
`default_nettype none

module psps_front
    import psps_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire psps_in_t  byte_item,
    output logic           item_valid,
    output cls_item_t      item,
    input  wire logic      take
);

    cls_item_t           mem [FQ_DEPTH];
    logic [FQ_AW-1:0]    wptr_reg, wptr_next;
    logic [FQ_AW-1:0]    rptr_reg, rptr_next;
    logic [FQ_AW:0]      count_reg, count_next;
    cls_item_t           cls_in;
    logic                wr_en;
    logic                rd_en;

    always_comb
    begin
        if (byte_item.data_byte inside {[8'h20:8'h7E]})
        begin
            cls_in.cls = CLS_PRINT;
        end
        else if (byte_item.data_byte == 8'h00)
        begin
            cls_in.cls = CLS_ZERO;
        end
        else
        begin
            cls_in.cls = CLS_OTHER;
        end
        cls_in.last = byte_item.last_byte;
    end

    assign full       = (count_reg == (FQ_AW+1)'(FQ_DEPTH));
    assign wr_en      = push && !full;
    assign item_valid = (count_reg != '0);
    assign rd_en      = take && item_valid;
    assign item       = mem[rptr_reg];

    always_comb
    begin
        wptr_next  = wr_en ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = rd_en ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + (FQ_AW+1)'(wr_en) - (FQ_AW+1)'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr_reg] <= cls_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/psps_back.sv =====
// Back end: run tracking, pool qualification and config registers.
// Depends on psps_pkg; feeds up to two records per byte to the result queue.
`default_nettype none

module psps_back
    import psps_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic      item_valid,
    input  wire cls_item_t item,
    output logic           take,
    input  wire logic      room,
    output rec_wr_t        rec_wr
);

    logic [31:0]      base_reg;
    logic [LEN_W-1:0] min_reg;
    logic [LEN_W-1:0] max_reg;
    logic [CNT_W-1:0] limit_reg;

    scan_mode_t       mode_reg, mode_next;
    logic [1:0]       skip_reg, skip_next;
    logic [31:0]      offset_reg, offset_next;
    logic [31:0]      start_reg, start_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] pcnt_reg, pcnt_next;
    logic [CNT_W-1:0] found_reg, found_next;

    logic [CNT_W-1:0] lim;
    logic [LEN_W-1:0] need;
    logic [LEN_W-1:0] max_eff;
    logic [31:0]      addr;
    logic             do_idle;
    logic [1:0]       n;
    psps_out_t        rec_v [2];

    assign take    = item_valid && room;
    assign lim     = (limit_reg < MAX_POOLS) ? limit_reg : MAX_POOLS;
    assign need    = (min_reg == '0) ? LEN_W'(1) : min_reg;
    assign max_eff = (max_reg == '0) ? LEN_W'(1) :
                     ((max_reg > RUN_CAP) ? RUN_CAP : max_reg);
    assign addr    = base_reg + offset_reg;

    always_comb
    begin
        mode_next   = mode_reg;
        skip_next   = skip_reg;
        offset_next = offset_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        pcnt_next   = pcnt_reg;
        found_next  = found_reg;
        do_idle     = 1'b0;
        n           = 2'd0;
        rec_v[0]    = '0;
        rec_v[1]    = '0;
        if (take)
        begin
            if (mode_reg == MODE_RUN)
            begin
                case (item.cls)
                    CLS_PRINT:
                    begin
                        pcnt_next = pcnt_next + 1'b1;
                        len_next  = len_next + 1'b1;
                    end
                    CLS_ZERO:
                    begin
                        len_next = len_next + 1'b1;
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                        if (pcnt_next >= need && found_next < lim)
                        begin
                            found_next = found_next + 1'b1;
                            rec_v[n[0]] = '{1'b1, start_next, len_next, 1'b0, found_next};
                            n = n + 1'b1;
                        end
                        len_next  = '0;
                        pcnt_next = '0;
                        do_idle   = 1'b1;
                    end
                endcase
            end
            else
            begin
                do_idle = 1'b1;
            end

            if (do_idle)
            begin
                if (skip_next != 2'd0)
                begin
                    skip_next = skip_next - 1'b1;
                end
                else if (found_next < lim)
                begin
                    if (item.cls == CLS_PRINT)
                    begin
                        mode_next  = MODE_RUN;
                        start_next = addr;
                        len_next   = LEN_W'(1);
                        pcnt_next  = LEN_W'(1);
                    end
                    else
                    begin
                        skip_next = SKIP_BYTES;
                    end
                end
            end

            // forced close at maximum length
            if (mode_next == MODE_RUN && len_next >= max_eff)
            begin
                mode_next = MODE_IDLE;
                if (pcnt_next >= need && found_next < lim)
                begin
                    found_next = found_next + 1'b1;
                    rec_v[n[0]] = '{1'b1, start_next, len_next, 1'b0, found_next};
                    n = n + 1'b1;
                end
                len_next  = '0;
                pcnt_next = '0;
            end

            offset_next = offset_reg + 32'd1;

            if (item.last)
            begin
                if (mode_next == MODE_RUN)
                begin
                    mode_next = MODE_IDLE;
                    if (pcnt_next >= need && found_next < lim)
                    begin
                        found_next = found_next + 1'b1;
                        rec_v[n[0]] = '{1'b1, start_next, len_next, 1'b0, found_next};
                        n = n + 1'b1;
                    end
                end
                rec_v[n[0]] = '{1'b0, 32'd0, LEN_W'(0), 1'b1, found_next};
                n           = n + 1'b1;
                mode_next   = MODE_IDLE;
                skip_next   = '0;
                offset_next = '0;
                start_next  = '0;
                len_next    = '0;
                pcnt_next   = '0;
                found_next  = '0;
            end
        end
    end

    always_comb
    begin
        rec_wr.cnt  = n;
        rec_wr.rec0 = rec_v[0];
        rec_wr.rec1 = rec_v[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= BASE_RST;
            min_reg   <= MIN_RST;
            max_reg   <= MAX_RST;
            limit_reg <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE:  base_reg  <= cfg_wdata;
                REG_MIN:   min_reg   <= cfg_wdata[LEN_W-1:0];
                REG_MAX:   max_reg   <= cfg_wdata[LEN_W-1:0];
                REG_LIMIT: limit_reg <= cfg_wdata[CNT_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            skip_reg   <= '0;
            offset_reg <= '0;
            start_reg  <= '0;
            len_reg    <= '0;
            pcnt_reg   <= '0;
            found_reg  <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            skip_reg   <= skip_next;
            offset_reg <= offset_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            pcnt_reg   <= pcnt_next;
            found_reg  <= found_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/psps_out_queue.sv =====
// Result queue: takes up to two records per cycle, hands out one.
// Depends on psps_pkg.
`default_nettype none

module psps_out_queue
    import psps_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire rec_wr_t rec_wr,
    output logic         room,
    output logic         empty,
    input  wire logic    pop,
    output psps_out_t    pool_rec
);

    psps_out_t        mem [OQ_DEPTH];
    logic [OQ_AW-1:0] wptr_reg, wptr_next;
    logic [OQ_AW-1:0] rptr_reg, rptr_next;
    logic [OQ_AW:0]   count_reg, count_next;
    logic             rd_en;

    // room for a full two-record write
    assign room     = (count_reg <= (OQ_AW+1)'(OQ_DEPTH - 2));
    assign empty    = (count_reg == '0);
    assign rd_en    = pop && !empty;
    assign pool_rec = mem[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg + OQ_AW'(rec_wr.cnt);
        rptr_next  = rd_en ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + (OQ_AW+1)'(rec_wr.cnt) - (OQ_AW+1)'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (rec_wr.cnt != 2'd0)
        begin
            mem[wptr_reg] <= rec_wr.rec0;
        end
        if (rec_wr.cnt == 2'd2)
        begin
            mem[wptr_reg + 1'b1] <= rec_wr.rec1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/printable_string_pool_scanner.sv =====
// Top level of the printable string pool scanner.
// Depends on psps_pkg, psps_front, psps_back, psps_out_queue, assert_macros.svh.
//
// Takes one byte per cycle while full is low and reports string pools found in
// the stream: each pool record gives start address, length and running pool count,
// and the byte flagged last_byte is followed by a done record, after which the scan
// state returns to its reset value while the registers keep their contents.
// A byte is classified on entry into a four-deep request queue; the run
// tracker takes one request per cycle whenever the four-deep result queue has
// room for two records, so the sustained rate is one byte per clock as long as
// results are popped about as fast as they appear. The records of a byte are
// written to the result queue when the run tracker takes its request.
`default_nettype none
`include "assert_macros.svh"

module printable_string_pool_scanner
    import psps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire psps_in_t    byte_item,
    output logic             empty,
    input  wire logic        pop,
    output psps_out_t        pool_rec,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    logic      item_valid;
    cls_item_t item;
    logic      take;
    logic      room;
    rec_wr_t   rec_wr;

    psps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .byte_item  (byte_item),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    psps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .room       (room),
        .rec_wr     (rec_wr)
    );

    psps_out_queue u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .rec_wr   (rec_wr),
        .room     (room),
        .empty    (empty),
        .pop      (pop),
        .pool_rec (pool_rec)
    );

    `CHK_IMPL(a_done_not_pool, !empty && pool_rec.scan_done, !pool_rec.pool_valid,
        "done record flagged as pool")
    `CHK_IMPL(a_pool_len, !empty && pool_rec.pool_valid,
        pool_rec.pool_length != '0 && pool_rec.pool_length <= RUN_CAP,
        "pool length out of range")
    `CHK_IMPL(a_pool_count, !empty && pool_rec.pool_valid,
        pool_rec.pools_total != '0 && pool_rec.pools_total <= MAX_POOLS,
        "pool count out of range")
    `CHK_ALWAYS(a_write_room, rec_wr.cnt == 2'd0 || (room && take),
        "records written without queue room")

endmodule

`default_nettype wire

// ===== dv/printable_string_pool_scanner_tb.sv =====
// Self-checking testbench for printable_string_pool_scanner: directed and random
// byte streams, register changes between scans, a scoreboard that predicts each record.
// Depends on psps_pkg and the RTL of the block only.
module printable_string_pool_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import psps_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 4000;

    class pool_scoreboard;
        logic [31:0]      base_reg;
        logic [LEN_W-1:0] min_reg;
        logic [LEN_W-1:0] max_reg;
        logic [CNT_W-1:0] limit_reg;
        scan_mode_t       mode;
        int unsigned      skip_left;
        logic [31:0]      offset;
        logic [31:0]      run_start;
        int unsigned      run_len;
        int unsigned      print_cnt;
        int unsigned      found;
        psps_out_t        expected_q[$];
        int unsigned      errors;
        int unsigned      pool_count;
        int unsigned      done_count;

        function new();
            base_reg   = BASE_RST;
            min_reg    = MIN_RST;
            max_reg    = MAX_RST;
            limit_reg  = LIMIT_RST;
            errors     = 0;
            pool_count = 0;
            done_count = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            mode      = MODE_IDLE;
            skip_left = 0;
            offset    = '0;
            run_start = '0;
            run_len   = 0;
            print_cnt = 0;
            found     = 0;
        endfunction

        function void write_reg(reg_index_t idx, logic [31:0] val);
            case (idx)
                REG_BASE:  base_reg  = val;
                REG_MIN:   min_reg   = val[LEN_W-1:0];
                REG_MAX:   max_reg   = val[LEN_W-1:0];
                REG_LIMIT: limit_reg = val[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function bit text_char(logic [7:0] b);
            return b >= 8'h20 && b <= 8'h7E;
        endfunction

        function int unsigned pool_cap();
            return (limit_reg < MAX_POOLS) ? limit_reg : MAX_POOLS;
        endfunction

        function int unsigned run_cap_now();
            if (max_reg == 0)
                return 1;
            if (max_reg > RUN_CAP)
                return RUN_CAP;
            return max_reg;
        endfunction

        function void add_record(logic valid, logic [31:0] start, int unsigned len,
                                 logic done);
            psps_out_t r;
            r.pool_valid  = valid;
            r.pool_start  = start;
            r.pool_length = LEN_W'(len);
            r.scan_done   = done;
            r.pools_total = CNT_W'(found);
            expected_q.push_back(r);
        endfunction

        function void close_run();
            int unsigned need;
            need = (min_reg == 0) ? 1 : min_reg;
            mode = MODE_IDLE;
            if (print_cnt >= need && found < pool_cap()) begin
                found++;
                pool_count++;
                add_record(1'b1, run_start, run_len, 1'b0);
            end
            run_len   = 0;
            print_cnt = 0;
        endfunction

        function void idle_byte(logic [7:0] b, logic [31:0] addr);
            if (skip_left != 0) begin
                skip_left--;
                return;
            end
            if (found >= pool_cap())
                return;
            if (text_char(b)) begin
                mode      = MODE_RUN;
                run_start = addr;
                run_len   = 1;
                print_cnt = 1;
            end
            else
                skip_left = SKIP_BYTES;
        endfunction

        function void note_byte(psps_in_t it);
            logic [31:0] addr;
            addr = base_reg + offset;
            if (mode == MODE_RUN) begin
                if (text_char(it.data_byte)) begin
                    print_cnt++;
                    run_len++;
                end
                else if (it.data_byte == 8'h00)
                    run_len++;
                else begin
                    close_run();
                    idle_byte(it.data_byte, addr);
                end
            end
            else
                idle_byte(it.data_byte, addr);
            if (mode == MODE_RUN && run_len >= run_cap_now())
                close_run();
            offset++;
            if (it.last_byte) begin
                if (mode == MODE_RUN)
                    close_run();
                add_record(1'b0, '0, 0, 1'b1);
                done_count++;
                clear_scan();
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_record(psps_out_t got);
            psps_out_t want;
            if (expected_q.size() == 0) begin
                $error("record 0x%0h arrived with nothing expected", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("pool_valid", want.pool_valid, got.pool_valid);
            compare_field("pool_start", want.pool_start, got.pool_start);
            compare_field("pool_length", want.pool_length, got.pool_length);
            compare_field("scan_done", want.scan_done, got.scan_done);
            compare_field("pools_total", want.pools_total, got.pools_total);
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             push;
    logic             full;
    psps_in_t         byte_item;
    logic             empty;
    logic             pop;
    psps_out_t        pool_rec;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [31:0]      cfg_wdata;

    pool_scoreboard   sb = new();
    bit               tx_idle = 1'b1;
    bit               rx_idle = 1'b1;
    int               hold_req = 0;
    int unsigned      progress = 0;
    int unsigned      bytes_sent = 0;
    int unsigned      settings_count = 0;

    printable_string_pool_scanner uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .byte_item (byte_item),
        .empty     (empty),
        .pop       (pop),
        .pool_rec  (pool_rec),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic logic [7:0] rand_printable();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    // non-printable and non-zero: closes a run
    function automatic logic [7:0] rand_other();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(8'h01, 8'h1F));
        return 8'($urandom_range(8'h7F, 8'hFF));
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic last);
        psps_in_t it;
        it.data_byte = data;
        it.last_byte = last;
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            @(negedge clk);
            push <= 1'b0;
            repeat ($urandom_range(0, 18)) @(negedge clk);
        end
        @(negedge clk);
        push      <= 1'b1;
        byte_item <= it;
        do @(posedge clk); while (full);
        sb.note_byte(it);
        bytes_sent++;
        progress++;
    endtask

    task automatic stop_push();
        @(negedge clk);
        push <= 1'b0;
    endtask

    // all records in, then a drain wait for requests that produce nothing
    task automatic settle();
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_one(input reg_index_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
    endtask

    task automatic set_regs(input logic [31:0] base, input logic [LEN_W-1:0] min_p,
                            input logic [LEN_W-1:0] max_r, input logic [CNT_W-1:0] lim);
        write_one(REG_BASE, base);
        write_one(REG_MIN, min_p);
        write_one(REG_MAX, max_r);
        write_one(REG_LIMIT, lim);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    // mostly well-formed runs with a closing byte and three skipped bytes,
    // some noise, some runs cut by the end of a scan
    task automatic scan_phase(input int n_bytes, input int run_lo, input int run_hi);
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < n_bytes) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                len = $urandom_range(run_lo, run_hi);
                for (int k = 0; k < len; k++)
                    send_byte((k > 0 && $urandom_range(0, 6) == 0) ? 8'h00 : rand_printable(),
                              1'b0);
                send_byte(rand_other(), 1'b0);
                repeat (3) send_byte(8'($urandom_range(0, 255)), 1'b0);
                sent += len + 4;
            end
            else if (pick < 9) begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
                sent++;
            end
            else begin
                len = $urandom_range(1, run_hi);
                for (int k = 0; k < len; k++)
                    send_byte(rand_printable(), k == len - 1);
                sent += len;
            end
        end
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        stop_push();
        settle();
    endtask

    initial
    begin : stimulus
        logic [7:0] walk_a [15] = '{8'h41, 8'h00, 8'h7E, 8'h01, 8'h20, 8'hFF, 8'h00,
                                    8'h20, 8'h41, 8'h00, 8'h42, 8'h43, 8'h44, 8'h80, 8'h41};
        logic [7:0] walk_b [10] = '{8'h7E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h00,
                                    8'h30, 8'h31, 8'h32, 8'h20};
        rst_n     = 1'b0;
        push      = 1'b0;
        byte_item = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_BASE;
        cfg_wdata = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // pool, skip, address wrap, close at max length, pool limit reached
        set_regs(32'hFFFF_FFFE, 13'd2, 13'd6, 5'd2);
        for (int i = 0; i < 15; i++)
            send_byte(walk_a[i], i == 14);
        stop_push();
        settle();

        // one-byte runs, zero byte while idle starts a skip
        set_regs(32'h0000_0000, 13'd1, 13'd1, 5'd16);
        for (int i = 0; i < 10; i++)
            send_byte(walk_b[i], i == 9);
        stop_push();
        settle();

        // open run dropped after the limit is lowered under it
        set_regs(32'hFFFF_FFFF, 13'd1, 13'd4096, 5'd16);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        stop_push();
        settle();
        set_regs(32'hFFFF_FFFF, 13'd1, 13'd4096, 5'd0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h41, 1'b1);
        stop_push();
        settle();

        set_regs(BASE_RST, MIN_RST, MAX_RST, LIMIT_RST);
        scan_phase(20, 18, 30);

        // receiver holds off while the sender keeps pushing
        set_regs($urandom, 13'd1, 13'd6, 5'd16);
        hold_req = HOLD_CYCLES;
        tx_idle  = 1'b0;
        scan_phase(20, 1, 8);
        tx_idle  = 1'b1;

        set_regs(32'hFFFF_FFF0, 13'd2, 13'd8, 5'd3);
        scan_phase(8, 2, 10);
        set_regs($urandom, 13'd1, 13'd1, 5'd16);
        scan_phase(10, 1, 4);
        set_regs(32'h0000_0000, 13'd4096, 13'd4096, 5'd5);
        scan_phase(8, 1, 6);
        set_regs(32'hFFFF_FFFF, 13'd1, 13'd4096, 5'd0);
        scan_phase(6, 1, 6);

        tx_idle = 1'b0;
        rx_idle = 1'b0;
        set_regs($urandom, 13'd5, 13'd12, 5'd16);
        scan_phase(12, 3, 16);

        $display("covered %0d bytes under %0d register settings", bytes_sent,
                 settings_count);
        $display("checked %0d pool records and %0d end-of-scan records",
                 sb.pool_count, sb.done_count);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("printable_string_pool_scanner_tb: clean");
        else
            $display("printable_string_pool_scanner_tb: errors");
        $finish;
    end

    initial
    begin : result_sink
        int stall;
        stall = 0;
        pop   = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req > 0) begin
                stall    = hold_req;
                hold_req = 0;
            end
            else if (stall == 0 && rx_idle && $urandom_range(0, 5) == 0)
                stall = $urandom_range(1, 19);
            pop <= (stall == 0);
            if (stall > 0)
                stall--;
            @(posedge clk);
            if (pop && !empty) begin
                sb.check_record(pool_rec);
                progress++;
            end
        end
    end

    initial
    begin : watchdog
        int unsigned seen;
        int unsigned stuck;
        seen  = 0;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT) begin
            @(negedge clk);
            if (progress != seen) begin
                seen  = progress;
                stuck = 0;
            end
            else
                stuck++;
        end
        $display("no request moved for %0d cycles, %0d records outstanding",
                 WATCHDOG_LIMIT, sb.expected_q.size());
        $display("printable_string_pool_scanner_tb: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/psps_pkg.sv
rtl/core/psps_front.sv
rtl/core/psps_back.sv
rtl/core/psps_out_queue.sv
rtl/core/printable_string_pool_scanner.sv
dv/printable_string_pool_scanner_tb.sv
